// ===== rtl/fema_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the free extent map allocator.
package fema_pkg;

    localparam int OFF_W               = 48;
    localparam int DEFAULT_MAX_EXTENTS = 1024;
    localparam int CFG_IDX_W           = 2;

    localparam logic [2:0] OP_MARK_FREE = 3'd0;
    localparam logic [2:0] OP_MARK_USED = 3'd1;
    localparam logic [2:0] OP_ALLOCATE  = 3'd2;
    localparam logic [2:0] OP_QUERY     = 3'd3;
    localparam logic [2:0] OP_REPORT    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_SIZE  = 2'd1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_INVALID    = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_NO_SPACE   = 2'd3
    } status_t;

    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [OFF_W-1:0] len;
    } ext_t;

    typedef struct packed {
        logic [2:0]       operation;
        logic [OFF_W-1:0] offset;
        logic [OFF_W-1:0] length;
    } in_t;

    typedef struct packed {
        logic             ok;
        status_t          status;
        logic [OFF_W-1:0] alloc_offset;
        logic [OFF_W-1:0] max_capacity;
        logic             at_tail;
        logic [OFF_W-1:0] used_boundary;
        logic [OFF_W-1:0] span_size;
        logic [OFF_W-1:0] live_size;
    } out_t;

endpackage

// ===== rtl/fema_ext_ram.sv =====
`timescale 1ns / 1ps
// Extent table memory: one write port, one registered read port with write forwarding.
module fema_ext_ram #(
    parameter int DEPTH = fema_pkg::DEFAULT_MAX_EXTENTS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                aclk,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output fema_pkg::ext_t      rdata,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  fema_pkg::ext_t      wdata
);

    fema_pkg::ext_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            if (we && waddr == raddr) begin
                rdata <= wdata;
            end else begin
                rdata <= mem[raddr];
            end
        end
    end

endmodule

// ===== rtl/fema_seq.sv =====
`timescale 1ns / 1ps
// Operation sequencer: scans, shifts and updates the extent table, holds the result word.
module fema_seq #(
    parameter int MAX_EXTENTS = fema_pkg::DEFAULT_MAX_EXTENTS,
    parameter int AW          = $clog2(MAX_EXTENTS),
    parameter int CW          = $clog2(MAX_EXTENTS + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2:0]                 in_op,
    input  logic [fema_pkg::OFF_W-1:0] in_off,
    input  logic [fema_pkg::OFF_W-1:0] in_len,
    input  logic [fema_pkg::OFF_W-1:0] space_size,
    input  logic                       space_we,
    output logic                       mem_re,
    output logic [AW-1:0]              mem_raddr,
    input  fema_pkg::ext_t             mem_rdata,
    output logic                       mem_we,
    output logic [AW-1:0]              mem_waddr,
    output fema_pkg::ext_t             mem_wdata,
    output logic                       m_valid,
    input  logic                       m_ready,
    output fema_pkg::out_t             m_data
);

    localparam int W = fema_pkg::OFF_W;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_RDLAST, S_WTLAST, S_SCRD, S_SCEV,
        S_UPRD, S_UPWR, S_DNRD, S_DNWR, S_DONE
    } state_t;

    state_t          state_reg;
    logic [2:0]      op_reg;
    logic [W-1:0]    s_reg, l_reg;
    logic [CW-1:0]   idx_reg, j_reg, p_reg, total_reg;
    fema_pkg::ext_t  prev_reg, last_reg, ins_reg;
    logic            has_last_reg, phase_reg;
    logic [W-1:0]    sc_reg, so_reg, sum_reg, big_off_reg, big_len_reg;
    logic            we_reg;
    logic [AW-1:0]   waddr_reg;
    fema_pkg::ext_t  wdata_reg;
    fema_pkg::out_t  res_reg, out_reg;
    logic            m_valid_reg;

    fema_pkg::ext_t  cur;
    logic [W-1:0]    cur_end, prev_end, e_in, u_room, left, right, tot_v;
    logic            range_bad, has_prev, nx_v, f_ovl, jl, jr, u_hit, q_hit, full;
    logic            free_go, at_end, is_last;
    logic [CW-1:0]   n_m1, j_m1, j_p1;

    assign in_ready  = state_reg == S_IDLE;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign mem_we    = we_reg;
    assign mem_waddr = waddr_reg;
    assign mem_wdata = wdata_reg;

    always_comb begin
        cur       = mem_rdata;
        cur_end   = cur.start + cur.len;
        prev_end  = prev_reg.start + prev_reg.len;
        e_in      = s_reg + l_reg;
        range_bad = (l_reg == '0) || (l_reg > ~s_reg);
        has_prev  = idx_reg != '0;
        nx_v      = state_reg == S_SCEV;
        f_ovl     = (has_prev && s_reg < prev_end) || (nx_v && e_in > cur.start);
        jl        = has_prev && prev_end == s_reg;
        jr        = nx_v && cur.start == e_in;
        u_hit     = cur.start <= s_reg && s_reg < cur_end;
        u_room    = cur_end - s_reg;
        left      = s_reg - cur.start;
        right     = cur_end - e_in;
        q_hit     = cur_end > s_reg && (cur.start <= s_reg || (cur.start - s_reg) < l_reg);
        full      = total_reg == CW'(MAX_EXTENTS);
        at_end    = idx_reg == total_reg;
        n_m1      = total_reg - CW'(1);
        j_m1      = j_reg - CW'(1);
        j_p1      = j_reg + CW'(1);
        is_last   = idx_reg + CW'(1) == total_reg;
        tot_v     = has_last_reg ? last_reg.start : space_size;
        free_go   = op_reg == fema_pkg::OP_MARK_FREE &&
                    ((state_reg == S_SCRD && at_end) ||
                     (state_reg == S_SCEV && cur.start > s_reg));
        mem_re    = 1'b0;
        mem_raddr = idx_reg[AW-1:0];
        unique case (state_reg)
            S_SCRD: begin
                mem_re = !at_end;
            end
            S_RDLAST: begin
                mem_re    = 1'b1;
                mem_raddr = n_m1[AW-1:0];
            end
            S_UPRD: begin
                mem_re    = j_reg != p_reg;
                mem_raddr = j_m1[AW-1:0];
            end
            S_DNRD: begin
                mem_re    = j_p1 < total_reg;
                mem_raddr = j_p1[AW-1:0];
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            total_reg   <= '0;
            big_off_reg <= '0;
            big_len_reg <= '0;
            we_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
        end else begin
            we_reg <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (space_we) begin
                total_reg   <= CW'(space_size != '0);
                big_off_reg <= '0;
                big_len_reg <= '0;
                we_reg      <= 1'b1;
                waddr_reg   <= '0;
                wdata_reg   <= '{start: '0, len: space_size};
            end
            priority if (free_go) begin
                priority if (f_ovl) begin
                    res_reg.status <= fema_pkg::ST_INVALID;
                    state_reg      <= S_DONE;
                end else if (jl && jr) begin
                    we_reg    <= 1'b1;
                    waddr_reg <= AW'(idx_reg - CW'(1));
                    wdata_reg <= '{start: prev_reg.start, len: prev_reg.len + l_reg + cur.len};
                    j_reg     <= idx_reg;
                    res_reg.ok <= 1'b1;
                    state_reg <= S_DNRD;
                end else if (jl) begin
                    we_reg    <= 1'b1;
                    waddr_reg <= AW'(idx_reg - CW'(1));
                    wdata_reg <= '{start: prev_reg.start, len: prev_reg.len + l_reg};
                    res_reg.ok <= 1'b1;
                    state_reg <= S_DONE;
                end else if (jr) begin
                    we_reg    <= 1'b1;
                    waddr_reg <= idx_reg[AW-1:0];
                    wdata_reg <= '{start: s_reg, len: cur.len + l_reg};
                    res_reg.ok <= 1'b1;
                    state_reg <= S_DONE;
                end else if (full) begin
                    res_reg.status <= fema_pkg::ST_TABLE_FULL;
                    state_reg      <= S_DONE;
                end else begin
                    ins_reg    <= '{start: s_reg, len: l_reg};
                    p_reg      <= idx_reg;
                    j_reg      <= total_reg;
                    res_reg.ok <= 1'b1;
                    state_reg  <= S_UPRD;
                end
            end else begin
                unique case (state_reg)
                    S_IDLE: begin
                        if (in_valid) begin
                            op_reg    <= in_op;
                            s_reg     <= in_off;
                            l_reg     <= in_len;
                            res_reg   <= '0;
                            phase_reg <= 1'b0;
                            idx_reg   <= '0;
                            sc_reg    <= '0;
                            so_reg    <= '0;
                            sum_reg   <= '0;
                            state_reg <= S_START;
                        end
                    end
                    S_START: begin
                        unique case (op_reg)
                            fema_pkg::OP_MARK_FREE, fema_pkg::OP_MARK_USED: begin
                                if (range_bad) begin
                                    res_reg.status <= fema_pkg::ST_INVALID;
                                    state_reg      <= S_DONE;
                                end else begin
                                    state_reg <= S_SCRD;
                                end
                            end
                            fema_pkg::OP_ALLOCATE: begin
                                if (total_reg == '0) begin
                                    big_len_reg    <= '0;
                                    res_reg.status <= fema_pkg::ST_NO_SPACE;
                                    state_reg      <= S_DONE;
                                end else begin
                                    state_reg <= S_RDLAST;
                                end
                            end
                            fema_pkg::OP_QUERY: begin
                                state_reg <= S_SCRD;
                            end
                            fema_pkg::OP_REPORT: begin
                                res_reg.ok <= 1'b1;
                                if (total_reg == '0) begin
                                    res_reg.used_boundary <= space_size;
                                    res_reg.span_size     <= space_size;
                                    res_reg.live_size     <= space_size;
                                    state_reg             <= S_DONE;
                                end else begin
                                    state_reg <= S_RDLAST;
                                end
                            end
                            default: begin
                                res_reg.status <= fema_pkg::ST_INVALID;
                                state_reg      <= S_DONE;
                            end
                        endcase
                    end
                    S_RDLAST: begin
                        state_reg <= S_WTLAST;
                    end
                    S_WTLAST: begin
                        last_reg     <= cur;
                        has_last_reg <= cur_end == space_size;
                        state_reg    <= S_SCRD;
                    end
                    S_SCRD: begin
                        if (at_end) begin
                            state_reg <= S_DONE;
                            unique case (op_reg)
                                fema_pkg::OP_MARK_USED: begin
                                    res_reg.status <= fema_pkg::ST_INVALID;
                                end
                                fema_pkg::OP_ALLOCATE: begin
                                    big_off_reg          <= so_reg;
                                    big_len_reg          <= sc_reg;
                                    res_reg.max_capacity <= sc_reg;
                                    if (!phase_reg) begin
                                        res_reg.status <= fema_pkg::ST_NO_SPACE;
                                    end
                                end
                                fema_pkg::OP_REPORT: begin
                                    res_reg.used_boundary <= tot_v;
                                    res_reg.span_size     <= tot_v;
                                    res_reg.live_size     <= tot_v - sum_reg;
                                    res_reg.max_capacity  <= sc_reg;
                                    big_off_reg           <= so_reg;
                                    big_len_reg           <= sc_reg;
                                end
                                default: begin
                                    res_reg.ok <= 1'b0;
                                end
                            endcase
                        end else begin
                            state_reg <= S_SCEV;
                        end
                    end
                    S_SCEV: begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_SCRD;
                        unique case (op_reg)
                            fema_pkg::OP_MARK_FREE: begin
                                prev_reg <= cur;
                            end
                            fema_pkg::OP_MARK_USED: begin
                                if (u_hit) begin
                                    idx_reg   <= idx_reg;
                                    state_reg <= S_DONE;
                                    priority if (l_reg > u_room) begin
                                        res_reg.status <= fema_pkg::ST_INVALID;
                                    end else if (left != '0 && right != '0) begin
                                        if (full) begin
                                            res_reg.status <= fema_pkg::ST_TABLE_FULL;
                                        end else begin
                                            we_reg     <= 1'b1;
                                            waddr_reg  <= idx_reg[AW-1:0];
                                            wdata_reg  <= '{start: cur.start, len: left};
                                            ins_reg    <= '{start: e_in, len: right};
                                            p_reg      <= idx_reg + CW'(1);
                                            j_reg      <= total_reg;
                                            res_reg.ok <= 1'b1;
                                            state_reg  <= S_UPRD;
                                        end
                                    end else if (left == '0 && right == '0) begin
                                        j_reg      <= idx_reg;
                                        res_reg.ok <= 1'b1;
                                        state_reg  <= S_DNRD;
                                    end else if (left == '0) begin
                                        we_reg     <= 1'b1;
                                        waddr_reg  <= idx_reg[AW-1:0];
                                        wdata_reg  <= '{start: e_in, len: right};
                                        res_reg.ok <= 1'b1;
                                    end else begin
                                        we_reg     <= 1'b1;
                                        waddr_reg  <= idx_reg[AW-1:0];
                                        wdata_reg  <= '{start: cur.start, len: left};
                                        res_reg.ok <= 1'b1;
                                    end
                                end
                            end
                            fema_pkg::OP_ALLOCATE: begin
                                if (!phase_reg && cur.len >= l_reg) begin
                                    idx_reg              <= idx_reg;
                                    res_reg.ok           <= 1'b1;
                                    res_reg.alloc_offset <= cur.start;
                                    res_reg.at_tail      <= has_last_reg &&
                                                            cur.start == last_reg.start;
                                    res_reg.max_capacity <= big_len_reg;
                                    phase_reg            <= cur.start == big_off_reg;
                                    if (cur.len == l_reg) begin
                                        j_reg     <= idx_reg;
                                        state_reg <= S_DNRD;
                                    end else begin
                                        we_reg    <= 1'b1;
                                        waddr_reg <= idx_reg[AW-1:0];
                                        wdata_reg <= '{start: cur.start + l_reg,
                                                       len: cur.len - l_reg};
                                        state_reg <= (cur.start == big_off_reg) ? S_SCRD
                                                                                : S_DONE;
                                    end
                                end else if (cur.len > sc_reg) begin
                                    sc_reg <= cur.len;
                                    so_reg <= cur.start;
                                end
                            end
                            fema_pkg::OP_QUERY: begin
                                if (q_hit) begin
                                    res_reg.ok <= 1'b1;
                                    state_reg  <= S_DONE;
                                end
                            end
                            default: begin
                                if (!(has_last_reg && is_last)) begin
                                    sum_reg <= sum_reg + cur.len;
                                end
                                if (cur.len > sc_reg) begin
                                    sc_reg <= cur.len;
                                    so_reg <= cur.start;
                                end
                            end
                        endcase
                    end
                    S_UPRD: begin
                        if (j_reg == p_reg) begin
                            we_reg    <= 1'b1;
                            waddr_reg <= p_reg[AW-1:0];
                            wdata_reg <= ins_reg;
                            total_reg <= total_reg + CW'(1);
                            state_reg <= S_DONE;
                        end else begin
                            state_reg <= S_UPWR;
                        end
                    end
                    S_UPWR: begin
                        we_reg    <= 1'b1;
                        waddr_reg <= j_reg[AW-1:0];
                        wdata_reg <= cur;
                        j_reg     <= j_m1;
                        state_reg <= S_UPRD;
                    end
                    S_DNRD: begin
                        if (j_p1 >= total_reg) begin
                            total_reg <= n_m1;
                            state_reg <= phase_reg ? S_SCRD : S_DONE;
                        end else begin
                            state_reg <= S_DNWR;
                        end
                    end
                    S_DNWR: begin
                        we_reg    <= 1'b1;
                        waddr_reg <= j_reg[AW-1:0];
                        wdata_reg <= cur;
                        j_reg     <= j_p1;
                        state_reg <= S_DNRD;
                    end
                    S_DONE: begin
                        if (!m_valid_reg || m_ready) begin
                            out_reg     <= res_reg;
                            m_valid_reg <= 1'b1;
                            state_reg   <= S_IDLE;
                        end
                    end
                    default: begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CW'(MAX_EXTENTS))
        else $error("extent count above table depth");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> state_reg == S_START)
        else $error("accepted word not started");

    a_ok_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(out_reg.ok && out_reg.status != fema_pkg::ST_OK))
        else $error("ok with failing status");

    a_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (we_reg && $past(state_reg) == S_IDLE) |-> $past(space_we))
        else $error("table write from idle without space write");

endmodule

// ===== rtl/free_extent_map_allocator_unit.sv =====
`timescale 1ns / 1ps
// Top level of the free extent map allocator: configuration registers, offset rebasing, table.
// One word is processed at a time. An operation passes through setup states, then through a
// read state and an evaluate or write state for every table entry it visits or moves: scans,
// inserts and deletes go through the single read port of the extent memory, one entry at a time;
// the worst case is a full scan followed by a full shift. The next word is taken as soon as the
// previous result sits in the output register. Writing space_size resets the table to one free
// extent (none when the size is zero); no clearing pass is needed.
module free_extent_map_allocator_unit #(
    parameter int MAX_EXTENTS = fema_pkg::DEFAULT_MAX_EXTENTS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  fema_pkg::in_t                  s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output fema_pkg::out_t                 m_data,
    input  logic                           cfg_we,
    input  logic [fema_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fema_pkg::OFF_W-1:0]     cfg_wdata
);

    localparam int AW = $clog2(MAX_EXTENTS);

    logic [fema_pkg::OFF_W-1:0] base_reg, space_reg, rel_off;
    logic                       space_we;
    logic                       mem_re, mem_we;
    logic [AW-1:0]              mem_raddr, mem_waddr;
    fema_pkg::ext_t             mem_rdata, mem_wdata;

    assign space_we = cfg_we && cfg_index == fema_pkg::REG_SPACE_SIZE;
    assign rel_off  = s_data.offset - base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            space_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == fema_pkg::REG_BASE_OFFSET) begin
                base_reg <= cfg_wdata;
            end
            if (space_we) begin
                space_reg <= cfg_wdata;
            end
        end
    end

    fema_seq #(
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_op      (s_data.operation),
        .in_off     (rel_off),
        .in_len     (s_data.length),
        .space_size (space_we ? cfg_wdata : space_reg),
        .space_we   (space_we),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    fema_ext_ram #(
        .DEPTH (MAX_EXTENTS),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata)
    );

endmodule
